### hdl/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg: shared types and constants for the selective-repeat sender window
// Op and result codes, sequencer states, configuration indexes and defaults.
// ----------------------------------------------------------------------------
package srsw_pkg;

  // Default sizing of the top level
  localparam int MAX_FRAMES_DEF = 64;
  localparam int MAX_WINDOW_DEF = 16;

  // Field widths fixed by the interface
  localparam int OP_W     = 2;
  localparam int SEQ_W    = 6;
  localparam int KIND_W   = 3;
  localparam int FRAME_W  = 6;
  localparam int BASE_W   = 7;
  localparam int TOTAL_W  = 7;
  localparam int WINDOW_W = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOTAL  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW = 1'd1;
  localparam logic [TOTAL_W-1:0]   TOTAL_RST  = 7'd10;
  localparam logic [WINDOW_W-1:0]  WINDOW_RST = 5'd4;

  // Request op codes
  localparam logic [OP_W-1:0] OP_SEND   = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK    = 2'd1;
  localparam logic [OP_W-1:0] OP_NACK   = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_SEND    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ACK     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NACK    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DONE    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SLIDE_RD,
    ST_SLIDE_CHK,
    ST_DECIDE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_REPLY
  } state_t;

endpackage

### hdl/selective_repeat_sender_window.sv
// ----------------------------------------------------------------------------
// selective_repeat_sender_window: sender side of selective-repeat ARQ
// Keeps an acked bitmap and a window base; answers send rounds, acks, nacks.
// ----------------------------------------------------------------------------
//  channel  signals                          direction  handshake
//  in       in_op, in_seq                    input      in_valid / in_ready
//  out      out_kind, out_frame,             output     out_valid / out_ready
//           out_window_base, out_last
//  cfg      cfg_index, cfg_data              input      cfg_we, no wait
//
// After reset a clearing pass walks the whole bitmap; no request is taken
// meanwhile. The bitmap RAM has one read port with a registered output, so
// each base slide step and each window scan step is split into a read state
// and a check state. Results wait in an output register; a stalled output
// holds the scan in place.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window #(
  parameter int MAX_FRAMES = srsw_pkg::MAX_FRAMES_DEF,
  parameter int MAX_WINDOW = srsw_pkg::MAX_WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [srsw_pkg::OP_W-1:0]         in_op,
  input  logic [srsw_pkg::SEQ_W-1:0]        in_seq,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [srsw_pkg::KIND_W-1:0]       out_kind,
  output logic [srsw_pkg::FRAME_W-1:0]      out_frame,
  output logic [srsw_pkg::BASE_W-1:0]       out_window_base,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [srsw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srsw_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW  = $clog2(MAX_FRAMES);
  localparam int BW  = $clog2(MAX_FRAMES + 1);
  localparam int WW  = $clog2(MAX_WINDOW + 1);
  localparam int CW  = (BW > srsw_pkg::TOTAL_W) ? BW : srsw_pkg::TOTAL_W;
  localparam int WCW = (WW > srsw_pkg::WINDOW_W) ? WW : srsw_pkg::WINDOW_W;
  localparam int SW  = ((BW > WW) ? BW : WW) + 1;

  srsw_pkg::state_t state_r, state_nxt;

  logic [srsw_pkg::TOTAL_W-1:0]  cfg_total_r;
  logic [srsw_pkg::WINDOW_W-1:0] cfg_window_r;

  logic [BW-1:0] base_r, base_nxt;
  logic [BW-1:0] idx_r, idx_nxt;
  logic [BW-1:0] end_r, end_nxt;
  logic [BW-1:0] tot_r, tot_nxt;
  logic [WW-1:0] win_r, win_nxt;
  logic [BW-1:0] pend_r, pend_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [srsw_pkg::OP_W-1:0]    op_r, op_nxt;
  logic [srsw_pkg::KIND_W-1:0]  rep_kind_r, rep_kind_nxt;
  logic [srsw_pkg::FRAME_W-1:0] rep_frame_r, rep_frame_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [srsw_pkg::KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic [srsw_pkg::FRAME_W-1:0] out_frame_r, out_frame_nxt;
  logic [srsw_pkg::BASE_W-1:0]  out_base_r, out_base_nxt;
  logic                         out_last_r, out_last_nxt;

  logic [CW-1:0]  total_ext;
  logic [BW-1:0]  total_eff;
  logic [WCW-1:0] window_ext;
  logic [WW-1:0]  window_eff;
  logic [SW-1:0]  win_end;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic          ram_rdata;

  logic in_acc;
  logic out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_total_r  <= srsw_pkg::TOTAL_RST;
      cfg_window_r <= srsw_pkg::WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        srsw_pkg::CFG_IDX_TOTAL:  cfg_total_r  <= cfg_data;
        srsw_pkg::CFG_IDX_WINDOW: cfg_window_r <= srsw_pkg::WINDOW_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Saturate registers into their usable ranges
  always_comb begin
    total_ext = CW'(cfg_total_r);
    if (total_ext == '0) begin
      total_eff = BW'(1);
    end else if (total_ext > CW'(MAX_FRAMES)) begin
      total_eff = BW'(MAX_FRAMES);
    end else begin
      total_eff = BW'(total_ext);
    end
    window_ext = WCW'(cfg_window_r);
    if (window_ext == '0) begin
      window_eff = WW'(1);
    end else if (window_ext > WCW'(MAX_WINDOW)) begin
      window_eff = WW'(MAX_WINDOW);
    end else begin
      window_eff = WW'(window_ext);
    end
  end

  assign in_ready  = (state_r == srsw_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign win_end   = SW'(base_r) + SW'(win_r);

  // Bitmap ports: clear pass or ack marking on write, base or scan index on read
  always_comb begin
    if (state_r == srsw_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = idx_r[AW-1:0];
      ram_wdata = 1'b0;
    end else begin
      ram_we    = in_acc && (in_op == srsw_pkg::OP_ACK) &&
                  (CW'(in_seq) < CW'(total_eff));
      ram_waddr = AW'(in_seq);
      ram_wdata = 1'b1;
    end
    if (state_r == srsw_pkg::ST_SLIDE_RD || state_r == srsw_pkg::ST_SLIDE_CHK) begin
      ram_raddr = base_r[AW-1:0];
    end else begin
      ram_raddr = idx_r[AW-1:0];
    end
  end

  srsw_ack_ram #(
    .DEPTH (MAX_FRAMES)
  ) u_ack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srsw_pkg::ST_CLEAR;
      base_r      <= '0;
      idx_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      idx_r       <= idx_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    end_r       <= end_nxt;
    tot_r       <= tot_nxt;
    win_r       <= win_nxt;
    pend_r      <= pend_nxt;
    op_r        <= op_nxt;
    rep_kind_r  <= rep_kind_nxt;
    rep_frame_r <= rep_frame_nxt;
    out_kind_r  <= out_kind_nxt;
    out_frame_r <= out_frame_nxt;
    out_base_r  <= out_base_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    idx_nxt       = idx_r;
    end_nxt       = end_r;
    tot_nxt       = tot_r;
    win_nxt       = win_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    op_nxt        = op_r;
    rep_kind_nxt  = rep_kind_r;
    rep_frame_nxt = rep_frame_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_frame_nxt = out_frame_r;
    out_base_nxt  = out_base_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      srsw_pkg::ST_CLEAR: begin
        idx_nxt = idx_r + BW'(1);
        if (idx_r == BW'(MAX_FRAMES - 1)) begin
          idx_nxt   = '0;
          state_nxt = srsw_pkg::ST_IDLE;
        end
      end

      srsw_pkg::ST_IDLE: begin
        if (in_acc) begin
          op_nxt        = in_op;
          tot_nxt       = total_eff;
          win_nxt       = window_eff;
          rep_frame_nxt = in_seq;
          if (in_op == srsw_pkg::OP_SEND) begin
            state_nxt = srsw_pkg::ST_SLIDE_RD;
          end else if (in_op == srsw_pkg::OP_UNUSED ||
                       CW'(in_seq) >= CW'(total_eff)) begin
            rep_kind_nxt = srsw_pkg::KIND_IGNORED;
            state_nxt    = srsw_pkg::ST_REPLY;
          end else if (in_op == srsw_pkg::OP_ACK) begin
            rep_kind_nxt = srsw_pkg::KIND_ACK;
            state_nxt    = srsw_pkg::ST_SLIDE_RD;
          end else begin
            rep_kind_nxt = srsw_pkg::KIND_NACK;
            state_nxt    = srsw_pkg::ST_REPLY;
          end
        end
      end

      // Advance the base past acked frames, one read per step
      srsw_pkg::ST_SLIDE_RD: begin
        if (base_r >= tot_r) begin
          state_nxt = srsw_pkg::ST_DECIDE;
        end else begin
          state_nxt = srsw_pkg::ST_SLIDE_CHK;
        end
      end

      srsw_pkg::ST_SLIDE_CHK: begin
        if (ram_rdata) begin
          base_nxt  = base_r + BW'(1);
          state_nxt = srsw_pkg::ST_SLIDE_RD;
        end else begin
          state_nxt = srsw_pkg::ST_DECIDE;
        end
      end

      srsw_pkg::ST_DECIDE: begin
        if (op_r == srsw_pkg::OP_ACK) begin
          state_nxt = srsw_pkg::ST_REPLY;
        end else if (base_r >= tot_r) begin
          rep_kind_nxt  = srsw_pkg::KIND_DONE;
          rep_frame_nxt = '0;
          state_nxt     = srsw_pkg::ST_REPLY;
        end else begin
          end_nxt    = (win_end < SW'(tot_r)) ? BW'(win_end) : tot_r;
          idx_nxt    = base_r;
          pend_v_nxt = 1'b0;
          state_nxt  = srsw_pkg::ST_SCAN_RD;
        end
      end

      // Walk the window; hold one found frame back so the last can be marked
      srsw_pkg::ST_SCAN_RD: begin
        if (idx_r < end_r) begin
          state_nxt = srsw_pkg::ST_SCAN_CHK;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = srsw_pkg::KIND_SEND;
          out_frame_nxt = srsw_pkg::FRAME_W'(pend_r);
          out_base_nxt  = srsw_pkg::BASE_W'(base_r);
          out_last_nxt  = 1'b1;
          state_nxt     = srsw_pkg::ST_IDLE;
        end
      end

      srsw_pkg::ST_SCAN_CHK: begin
        if (ram_rdata) begin
          idx_nxt   = idx_r + BW'(1);
          state_nxt = srsw_pkg::ST_SCAN_RD;
        end else if (!pend_v_r) begin
          pend_nxt   = idx_r;
          pend_v_nxt = 1'b1;
          idx_nxt    = idx_r + BW'(1);
          state_nxt  = srsw_pkg::ST_SCAN_RD;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = srsw_pkg::KIND_SEND;
          out_frame_nxt = srsw_pkg::FRAME_W'(pend_r);
          out_base_nxt  = srsw_pkg::BASE_W'(base_r);
          out_last_nxt  = 1'b0;
          pend_nxt      = idx_r;
          idx_nxt       = idx_r + BW'(1);
          state_nxt     = srsw_pkg::ST_SCAN_RD;
        end
      end

      srsw_pkg::ST_REPLY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = rep_kind_r;
          out_frame_nxt = rep_frame_r;
          out_base_nxt  = srsw_pkg::BASE_W'(base_r);
          out_last_nxt  = 1'b1;
          state_nxt     = srsw_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = srsw_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_frame       = out_frame_r;
  assign out_window_base = out_base_r;
  assign out_last        = out_last_r;

endmodule

### hdl/srsw_ack_ram.sv
// ----------------------------------------------------------------------------
// srsw_ack_ram: acknowledged-frame bitmap
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module srsw_ack_ram #(
  parameter int DEPTH = srsw_pkg::MAX_FRAMES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic                     wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic                     rdata
);

  logic mem [DEPTH];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### dv/srsw_window_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsw_window_checker: result checker for the selective-repeat sender window
// Watches the request, result and register ports, predicts every result from
// its own copy of the acked bitmap, window base and registers, and compares.
// ----------------------------------------------------------------------------
module srsw_window_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [srsw_pkg::OP_W-1:0]       in_op,
  input  logic [srsw_pkg::SEQ_W-1:0]      in_seq,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [srsw_pkg::KIND_W-1:0]     out_kind,
  input  logic [srsw_pkg::FRAME_W-1:0]    out_frame,
  input  logic [srsw_pkg::BASE_W-1:0]     out_window_base,
  input  logic                            out_last,
  input  logic                            cfg_we,
  input  logic [srsw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srsw_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              results_seen,
  output int                              outstanding,
  output logic [srsw_pkg::BASE_W-1:0]     window_base_now
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [srsw_pkg::KIND_W-1:0]  kind;
    logic [srsw_pkg::FRAME_W-1:0] frame;
    logic [srsw_pkg::BASE_W-1:0]  base;
    logic                         last;
  } reply_t;

  logic                          acked [srsw_pkg::MAX_FRAMES_DEF];
  logic [srsw_pkg::BASE_W-1:0]   base_q;
  logic [srsw_pkg::TOTAL_W-1:0]  total_q;
  logic [srsw_pkg::WINDOW_W-1:0] window_q;
  reply_t                        pending_replies [$];
  reply_t                        seen;
  reply_t                        want;

  function automatic reply_t make_reply(input logic [srsw_pkg::KIND_W-1:0] kind,
                                        input logic [srsw_pkg::FRAME_W-1:0] frame,
                                        input logic last);
    return '{kind: kind, frame: frame, base: base_q, last: last};
  endfunction

  // advance the base past every acked frame below the effective total
  task automatic slide_base(input int lim);
    while (base_q < lim && base_q < srsw_pkg::MAX_FRAMES_DEF && acked[base_q])
      base_q++;
  endtask

  task automatic forecast_replies(input logic [srsw_pkg::OP_W-1:0] op,
                                  input logic [srsw_pkg::SEQ_W-1:0] seq);
    int lim;
    int span;
    int stop;
    int hi;
    lim  = (total_q == 0) ? 1 :
           (total_q > srsw_pkg::MAX_FRAMES_DEF) ? srsw_pkg::MAX_FRAMES_DEF : int'(total_q);
    span = (window_q == 0) ? 1 :
           (window_q > srsw_pkg::MAX_WINDOW_DEF) ? srsw_pkg::MAX_WINDOW_DEF : int'(window_q);
    if (op == srsw_pkg::OP_SEND) begin
      slide_base(lim);
      if (base_q >= lim) begin
        pending_replies.push_back(make_reply(srsw_pkg::KIND_DONE, '0, 1'b1));
      end else begin
        stop = base_q + span;
        if (stop > lim) stop = lim;
        hi = base_q;
        for (int i = base_q; i < stop; i++)
          if (!acked[i]) hi = i;
        for (int i = base_q; i < stop; i++)
          if (!acked[i])
            pending_replies.push_back(make_reply(srsw_pkg::KIND_SEND,
                                                 srsw_pkg::FRAME_W'(i), i == hi));
      end
    end else if (op == srsw_pkg::OP_UNUSED || seq >= lim) begin
      pending_replies.push_back(make_reply(srsw_pkg::KIND_IGNORED, seq, 1'b1));
    end else if (op == srsw_pkg::OP_ACK) begin
      acked[seq] = 1'b1;
      slide_base(lim);
      pending_replies.push_back(make_reply(srsw_pkg::KIND_ACK, seq, 1'b1));
    end else begin
      pending_replies.push_back(make_reply(srsw_pkg::KIND_NACK, seq, 1'b1));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (acked[i]) acked[i] = 1'b0;
      base_q   = '0;
      total_q  = srsw_pkg::TOTAL_RST;
      window_q = srsw_pkg::WINDOW_RST;
      pending_replies.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen = '{kind: out_kind, frame: out_frame, base: out_window_base, last: out_last};
        results_seen++;
        if (pending_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected result kind/frame/base/last %0d/%0d/%0d/%0d",
                     $realtime, seen.kind, seen.frame, seen.base, seen.last);
        end else begin
          want = pending_replies.pop_front();
          if (seen.kind !== want.kind || seen.frame !== want.frame ||
              seen.base !== want.base || seen.last !== want.last) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display({"%0t: result mismatch kind/frame/base/last expected ",
                        "%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d"},
                       $realtime, want.kind, want.frame, want.base, want.last,
                       seen.kind, seen.frame, seen.base, seen.last);
          end
        end
      end
      if (in_valid && in_ready)
        forecast_replies(in_op, in_seq);
      if (cfg_we) begin
        case (cfg_index)
          srsw_pkg::CFG_IDX_TOTAL:  total_q  = cfg_data[srsw_pkg::TOTAL_W-1:0];
          srsw_pkg::CFG_IDX_WINDOW: window_q = cfg_data[srsw_pkg::WINDOW_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding     <= pending_replies.size();
    window_base_now <= base_q;
  end

endmodule

### dv/selective_repeat_sender_window_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_tb: regression for the sender window
// Directed send rounds, acks, nacks and ignored requests, then random traffic
// over several register settings with random idling, a long result stall and
// a full drain; results are checked by srsw_window_checker.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window_tb;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 75;
  localparam int PHASE_COUNT  = 6;
  localparam int TAIL_CYCLES  = 200;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic [srsw_pkg::OP_W-1:0]       in_op     = srsw_pkg::OP_SEND;
  logic [srsw_pkg::SEQ_W-1:0]      in_seq    = '0;
  logic                            out_ready = 1'b0;
  logic                            cfg_we    = 1'b0;
  logic [srsw_pkg::CFG_IDX_W-1:0]  cfg_index = srsw_pkg::CFG_IDX_TOTAL;
  logic [srsw_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  logic                            in_ready;
  logic                            out_valid;
  logic [srsw_pkg::KIND_W-1:0]     out_kind;
  logic [srsw_pkg::FRAME_W-1:0]    out_frame;
  logic [srsw_pkg::BASE_W-1:0]     out_window_base;
  logic                            out_last;

  int                              fail_count;
  int                              results_seen;
  int                              outstanding;
  logic [srsw_pkg::BASE_W-1:0]     window_base_now;

  int                              src_idle_pct = 38;
  int                              snk_idle_pct = 53;
  bit                              hold_req = 1'b0;
  int                              hold_left = 0;
  int                              cycle_cnt = 0;
  int                              requests_sent = 0;
  int                              settings_used = 0;
  logic [srsw_pkg::TOTAL_W-1:0]    phase_total  [PHASE_COUNT];
  logic [srsw_pkg::WINDOW_W-1:0]   phase_window [PHASE_COUNT];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  selective_repeat_sender_window dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_seq          (in_seq),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_frame       (out_frame),
    .out_window_base (out_window_base),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  srsw_window_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_seq          (in_seq),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_frame       (out_frame),
    .out_window_base (out_window_base),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .results_seen    (results_seen),
    .outstanding     (outstanding),
    .window_base_now (window_base_now)
  );

  // result side: random stalls, or a long hold-off when asked for
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("selective_repeat_sender_window regression: fail");
      $finish;
    end
  end

  // present one request and hold it until the block takes it
  task automatic offer(input logic [srsw_pkg::OP_W-1:0] op,
                       input logic [srsw_pkg::SEQ_W-1:0] seq);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_seq   <= seq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  // drop valid and wait for every predicted result
  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic configure(input logic [srsw_pkg::TOTAL_W-1:0] frames,
                           input logic [srsw_pkg::WINDOW_W-1:0] width);
    cfg_we    <= 1'b1;
    cfg_index <= srsw_pkg::CFG_IDX_TOTAL;
    cfg_data  <= frames;
    @(posedge clk);
    // upper data bits are junk for the window register
    cfg_index <= srsw_pkg::CFG_IDX_WINDOW;
    cfg_data  <= {2'($urandom_range(3)), width};
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    int                         roll;
    int                         span;
    logic [srsw_pkg::OP_W-1:0]  op;
    logic [srsw_pkg::SEQ_W-1:0] seq;
    phase_total  = '{7'd16, 7'd24, 7'd0, 7'd40, 7'd64, 7'd127};
    phase_window = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd9};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: ten frames, window of four
    offer(srsw_pkg::OP_SEND, 6'd0);
    offer(srsw_pkg::OP_NACK, 6'd0);
    offer(srsw_pkg::OP_ACK, 6'd0);
    offer(srsw_pkg::OP_ACK, 6'd2);
    offer(srsw_pkg::OP_SEND, 6'd63);
    offer(srsw_pkg::OP_ACK, 6'd2);
    offer(srsw_pkg::OP_ACK, 6'd63);
    offer(srsw_pkg::OP_NACK, 6'd10);
    offer(srsw_pkg::OP_UNUSED, 6'd0);
    offer(srsw_pkg::OP_UNUSED, 6'd63);
    offer(srsw_pkg::OP_ACK, 6'd1);
    offer(srsw_pkg::OP_NACK, 6'd9);
    offer(srsw_pkg::OP_ACK, 6'd9);
    offer(srsw_pkg::OP_SEND, 6'd0);

    // shrink the total down to the base, then saturate both registers
    drain_replies();
    configure(7'd3, 5'd16);
    offer(srsw_pkg::OP_SEND, 6'd0);
    offer(srsw_pkg::OP_ACK, 6'd5);
    drain_replies();
    configure(7'd127, 5'd0);
    offer(srsw_pkg::OP_SEND, 6'd21);
    offer(srsw_pkg::OP_ACK, 6'd63);
    offer(srsw_pkg::OP_NACK, 6'd63);
    offer(srsw_pkg::OP_SEND, 6'd0);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain_replies();
      configure(phase_total[p], phase_window[p]);
      if (p < 2) begin
        src_idle_pct = 38;
        snk_idle_pct = 53;
      end else if (p < 4) begin
        src_idle_pct = 53;
        snk_idle_pct = 38;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      span = (phase_window[p] == 0) ? 1 :
             (phase_window[p] > srsw_pkg::MAX_WINDOW_DEF) ? srsw_pkg::MAX_WINDOW_DEF :
             int'(phase_window[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 1 && k == 20) hold_req = 1'b1;
        if (p == 3 && k == 40) drain_replies();
        roll = $urandom_range(99);
        // acks mostly land inside the window so the base keeps moving
        if (roll < 35) begin
          op  = srsw_pkg::OP_SEND;
          seq = srsw_pkg::SEQ_W'($urandom_range(63));
        end else if (roll < 70) begin
          op  = srsw_pkg::OP_ACK;
          seq = ($urandom_range(99) < 80) ?
                srsw_pkg::SEQ_W'(window_base_now + $urandom_range(span - 1)) :
                srsw_pkg::SEQ_W'($urandom_range(63));
        end else if (roll < 90) begin
          op  = srsw_pkg::OP_NACK;
          seq = ($urandom_range(99) < 70) ?
                srsw_pkg::SEQ_W'(window_base_now + $urandom_range(span - 1)) :
                srsw_pkg::SEQ_W'($urandom_range(63));
        end else begin
          op  = srsw_pkg::OP_UNUSED;
          seq = srsw_pkg::SEQ_W'($urandom_range(63));
        end
        offer(op, seq);
      end
    end

    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d requests and %0d checked results over %0d register settings",
             requests_sent, results_seen, settings_used);
    $display("idling mixes 38/53, 53/38 and none; one %0d-cycle result stall, final base %0d",
             HOLD_CYCLES, window_base_now);
    if (fail_count == 0) begin
      $display("selective_repeat_sender_window regression: pass");
    end else begin
      $display("selective_repeat_sender_window regression: fail");
    end
    $finish;
  end

endmodule
